>>> hdl/mfb_pkg.sv
package mfb_pkg;

	localparam int DEF_COLS = 128;
	localparam int DEF_ROWS = 64;

	localparam logic [3:0] OP_PIX_WR  = 4'd0;
	localparam logic [3:0] OP_PIX_RD  = 4'd1;
	localparam logic [3:0] OP_HLINE   = 4'd2;
	localparam logic [3:0] OP_VLINE   = 4'd3;
	localparam logic [3:0] OP_RECT    = 4'd4;
	localparam logic [3:0] OP_FILL    = 4'd5;
	localparam logic [3:0] OP_SWAP    = 4'd6;
	localparam logic [3:0] OP_XSTART  = 4'd7;
	localparam logic [3:0] OP_XDONE   = 4'd8;
	localparam logic [3:0] OP_DISP_RD = 4'd9;

	typedef struct packed {
		logic [3:0] op;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] len;
		logic [7:0] w;
		logic [7:0] h;
		logic       on;
		logic       filled;
		logic [7:0] pattern;
		logic [9:0] idx;
	} cmd_t;

endpackage

>>> hdl/mono_framebuffer_draw_engine.sv
// Double-buffered 1 bpp frame store with column-byte bands. Each command is
// popped from the queue and ends in a result stage and a result beat; a status
// or unused command goes straight from the pop to the result stage, a pixel or
// display read adds a byte read, and a pixel write a byte read, then a write.
// A line or rectangle reads each walked pixel and writes it where it is in the
// frame, with a setup step per segment; a segment on a row or column outside the
// frame still walks up to the frame edge, and a filled rectangle has one segment
// per row. A fill writes each page byte in turn. After reset both pages are
// cleared by a sweep of every byte before the first command is taken. One
// result beat is produced per command beat, in order.
module mono_framebuffer_draw_engine import mfb_pkg::*; #(
	parameter int FRAME_COLS = DEF_COLS,
	parameter int FRAME_ROWS = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [3:0] operation,
	input  logic [7:0] x_pos,
	input  logic [7:0] y_pos,
	input  logic [7:0] line_length,
	input  logic [7:0] rect_width,
	input  logic [7:0] rect_height,
	input  logic       pixel_on,
	input  logic       filled,
	input  logic [7:0] fill_pattern,
	input  logic [9:0] display_index,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       pixel_value,
	output logic [7:0] display_byte,
	output logic       swap_waiting,
	output logic       can_transfer
);

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_pop;

	assign in_cmd = '{op: operation, x: x_pos, y: y_pos, len: line_length, w: rect_width,
		h: rect_height, on: pixel_on, filled: filled, pattern: fill_pattern,
		idx: display_index};

	mfb_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	mfb_back #(.COLS(FRAME_COLS), .ROWS(FRAME_ROWS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value),
		.display_byte(display_byte), .swap_waiting(swap_waiting),
		.can_transfer(can_transfer)
	);

endmodule

>>> hdl/mfb_ram.sv
module mfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/mfb_front.sv
module mfb_front import mfb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  cmd_t in_cmd,
	output logic q_valid,
	input  logic q_pop,
	output cmd_t q_cmd
);

	// two-entry queue between decode side and drawing engine
	cmd_t       buf_q [2];
	logic [1:0] cnt_q;
	logic       rd_q;
	logic       push;

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			buf_q[rd_q ^ cnt_q[0]] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
		end else begin
			if (q_pop)
				rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

`ifndef SYNTH
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_pop) |=> in_stall) else $error("full queue not stalling");
`endif

endmodule

>>> hdl/mfb_back.sv
module mfb_back import mfb_pkg::*; #(
	parameter int COLS = DEF_COLS,
	parameter int ROWS = DEF_ROWS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_valid,
	output logic       q_pop,
	input  cmd_t       q_cmd,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       pixel_value,
	output logic [7:0] display_byte,
	output logic       swap_waiting,
	output logic       can_transfer
);

	localparam int BANDS = (ROWS + 7) / 8;
	localparam int PAGE  = BANDS * COLS;
	localparam int AW    = $clog2(2 * PAGE);
	localparam int PW    = AW;

	localparam logic [2:0] ST_CLR   = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_WR    = 3'd3;
	localparam logic [2:0] ST_FILL  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0]    st_q;
	logic [PW-1:0] clr_q;
	cmd_t          c_q;
	logic          page_q, swap_q, busy_q;
	// pixel walk: current coordinate, remaining count, segment number
	logic [8:0]    px_q, py_q;
	logic [8:0]    rem_q;
	logic [8:0]    row_q;
	logic [1:0]    seg_q;
	logic          vert_q;
	logic          pix_q;
	logic [7:0]    byte_q;
	logic          ovalid_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata, rdata;

	mfb_ram #(.WIDTH(8), .DEPTH(2 * PAGE)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] pix_addr(input logic pg, input logic [8:0] x,
		input logic [8:0] y);
		logic [AW:0] a;
		a = (AW+1)'(y[8:3]) * (AW+1)'(COLS) + (AW+1)'(x) + (pg ? (AW+1)'(PAGE) : '0);
		return a[AW-1:0];
	endfunction

	logic in_frame, seg_live;
	assign in_frame = (px_q < 9'(COLS)) && (py_q < 9'(ROWS));
	// a line segment stops at its count or the frame edge
	assign seg_live = (rem_q != 0) && (vert_q ? (py_q < 9'(ROWS)) : (px_q < 9'(COLS)));

	// the byte for a pixel read is fetched while the command is popped
	assign raddr = (st_q == ST_IDLE) ?
		((q_cmd.op == OP_DISP_RD) ? AW'(q_cmd.idx) + (page_q ? AW'(0) : AW'(PAGE)) :
			pix_addr(page_q, {1'b0, q_cmd.x}, {1'b0, q_cmd.y})) :
		pix_addr(page_q, px_q, py_q);

	logic [7:0] mask;
	assign mask = 8'(1) << py_q[2:0];

	always_comb begin
		we    = 1'b0;
		waddr = pix_addr(page_q, px_q, py_q);
		// lines and rectangles always set pixels
		wdata = (c_q.on || c_q.op != OP_PIX_WR) ? (rdata | mask) : (rdata & ~mask);
		if (st_q == ST_CLR) begin
			we    = 1'b1;
			waddr = AW'(clr_q);
			wdata = '0;
		end else if (st_q == ST_FILL) begin
			we    = 1'b1;
			waddr = AW'(clr_q) + (page_q ? AW'(PAGE) : AW'(0));
			wdata = c_q.pattern;
		end else if (st_q == ST_WR) begin
			we = in_frame && (c_q.op == OP_PIX_WR || seg_live);
		end
	end

	assign q_pop        = (st_q == ST_IDLE) && q_valid && !ovalid_q;
	assign out_valid    = ovalid_q;
	assign pixel_value  = pix_q;
	assign display_byte = byte_q;
	assign swap_waiting = swap_q;
	assign can_transfer = !busy_q;

	// sets up the next segment of a line, rect or filled rect
	task automatic next_seg(input cmd_t c, input logic [1:0] s, input logic [8:0] r);
		logic       vv;
		logic [7:0] nx;
		logic [7:0] ny;
		logic [7:0] nr;
		vv = 1'b0;
		nx = c.x;
		ny = c.y;
		nr = c.w;
		if (c.op == OP_HLINE)
			nr = c.len;
		else if (c.op == OP_VLINE) begin
			vv = 1'b1;
			nr = c.len;
		end else if (c.filled) begin
			ny = 8'(c.y + r[7:0]);
			// zero height draws no row at all
			if (c.h == 8'd0)
				nr = 8'd0;
		end else begin
			unique case (s)
				2'd0: ;
				2'd1: ny = 8'(c.y + c.h + 8'hff);
				2'd2: begin
					vv = 1'b1;
					nr = c.h;
				end
				default: begin
					vv = 1'b1;
					nr = c.h;
					nx = 8'(c.x + c.w + 8'hff);
				end
			endcase
		end
		vert_q <= vv;
		seg_q  <= s;
		row_q  <= r;
		px_q   <= {1'b0, nx};
		py_q   <= {1'b0, ny};
		rem_q  <= {1'b0, nr};
	endtask

	logic last_seg;
	assign last_seg = (c_q.op == OP_HLINE || c_q.op == OP_VLINE) ? 1'b1 :
		c_q.filled ? (row_q + 9'd1 >= {1'b0, c_q.h}) : (seg_q == 2'd3);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: if (q_pop) begin
				c_q    <= q_cmd;
				byte_q <= '0;
				pix_q  <= 1'b0;
				if (q_cmd.op == OP_HLINE || q_cmd.op == OP_VLINE || q_cmd.op == OP_RECT)
					next_seg(q_cmd, 2'd0, 9'd0);
				else begin
					px_q <= {1'b0, q_cmd.x};
					py_q <= {1'b0, q_cmd.y};
				end
			end
			ST_RD: begin
				if (c_q.op == OP_PIX_RD)
					pix_q <= in_frame && rdata[py_q[2:0]];
				if (c_q.op == OP_DISP_RD)
					byte_q <= (32'(c_q.idx) < PAGE) ? rdata : 8'd0;
			end
			ST_WR: if (c_q.op != OP_PIX_WR) begin
				if (seg_live) begin
					rem_q <= rem_q - 9'd1;
					if (vert_q) py_q <= py_q + 9'd1;
					else        px_q <= px_q + 9'd1;
				end else if (!last_seg)
					next_seg(c_q, seg_q + 2'd1, row_q + 9'd1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLR;
			clr_q    <= '0;
			page_q   <= 1'b0;
			swap_q   <= 1'b0;
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall)
				ovalid_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					if ((AW+1)'(clr_q) + (AW+1)'(1) >= (AW+1)'(2 * PAGE)) begin
						st_q  <= ST_IDLE;
						clr_q <= '0;
					end else
						clr_q <= clr_q + PW'(1);
				end
				ST_IDLE: if (q_pop) begin
					clr_q <= '0;
					case (q_cmd.op)
						OP_PIX_RD, OP_DISP_RD, OP_PIX_WR, OP_HLINE, OP_VLINE, OP_RECT:
							st_q <= ST_RD;
						OP_FILL: st_q <= ST_FILL;
						OP_SWAP: begin
							swap_q <= 1'b1;
							st_q   <= ST_OUT;
						end
						OP_XSTART: begin
							busy_q <= 1'b1;
							st_q   <= ST_OUT;
						end
						OP_XDONE: begin
							busy_q <= 1'b0;
							if (swap_q) begin
								page_q <= !page_q;
								swap_q <= 1'b0;
							end
							st_q <= ST_OUT;
						end
						default: st_q <= ST_OUT;
					endcase
				end
				ST_RD: st_q <= (c_q.op == OP_PIX_RD || c_q.op == OP_DISP_RD) ? ST_OUT : ST_WR;
				ST_WR: begin
					if (c_q.op == OP_PIX_WR || (!seg_live && last_seg))
						st_q <= ST_OUT;
					else
						st_q <= ST_RD;
				end
				ST_FILL: begin
					clr_q <= clr_q + PW'(1);
					if (clr_q == PW'(PAGE - 1))
						st_q <= ST_OUT;
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					st_q     <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |=> out_valid) else $error("result not raised");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (st_q == ST_IDLE && !out_valid)) else $error("pop while busy");
	a_write_in_page: assert property (@(posedge clk) disable iff (!arst_n)
		(we && st_q == ST_WR) |-> (in_frame)) else $error("write outside frame");
`endif

endmodule

>>> dv/tb_mono_framebuffer_draw_engine.sv
module tb_mono_framebuffer_draw_engine;
	import mfb_pkg::*;

	localparam int COLS = DEF_COLS;
	localparam int ROWS = DEF_ROWS;
	localparam int BANDS = (ROWS + 7) / 8;
	localparam int PAGE_SZ = BANDS * COLS;

	typedef struct packed {
		logic       pix;
		logic [7:0] dbyte;
		logic       swp;
		logic       xfer_ok;
	} status_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [3:0] operation;
	logic [7:0] x_pos;
	logic [7:0] y_pos;
	logic [7:0] line_length;
	logic [7:0] rect_width;
	logic [7:0] rect_height;
	logic       pixel_on;
	logic       filled;
	logic [7:0] fill_pattern;
	logic [9:0] display_index;
	logic       out_valid;
	logic       out_stall;
	logic       pixel_value;
	logic [7:0] display_byte;
	logic       swap_waiting;
	logic       can_transfer;

	mono_framebuffer_draw_engine u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .x_pos(x_pos), .y_pos(y_pos),
		.line_length(line_length), .rect_width(rect_width),
		.rect_height(rect_height), .pixel_on(pixel_on), .filled(filled),
		.fill_pattern(fill_pattern), .display_index(display_index),
		.out_valid(out_valid), .out_stall(out_stall), .pixel_value(pixel_value),
		.display_byte(display_byte), .swap_waiting(swap_waiting),
		.can_transfer(can_transfer)
	);

	// shadow of the frame store
	logic [7:0] pages[2][PAGE_SZ];
	logic       draw_sel;
	logic       swap_req;
	logic       busy;

	cmd_t    cmd_q[$];
	status_t status_q[$];
	int      errors;
	bit      hold_sender;
	int      in_gap;
	int      out_gap;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic plot(int px, int py);
		if (px < COLS && py < ROWS)
			pages[draw_sel][(py / 8) * COLS + px][py % 8] = 1'b1;
	endtask

	task automatic span_h(int px, int py, int n);
		for (int i = 0; i < n && px + i < COLS; i++)
			plot(px + i, py);
	endtask

	task automatic span_v(int px, int py, int n);
		for (int i = 0; i < n && py + i < ROWS; i++)
			plot(px, py + i);
	endtask

	task automatic apply_cmd(input cmd_t c, output status_t s);
		logic [7:0] px2;
		logic [7:0] py2;
		s = '0;
		case (c.op)
			OP_PIX_WR: if (c.x < COLS && c.y < ROWS)
				pages[draw_sel][(c.y / 8) * COLS + c.x][c.y % 8] = c.on;
			OP_PIX_RD: if (c.x < COLS && c.y < ROWS)
				s.pix = pages[draw_sel][(c.y / 8) * COLS + c.x][c.y % 8];
			OP_HLINE: span_h(c.x, c.y, c.len);
			OP_VLINE: span_v(c.x, c.y, c.len);
			OP_RECT: begin
				// far edges wrap mod 256
				px2 = c.x + c.w - 8'd1;
				py2 = c.y + c.h - 8'd1;
				if (c.filled) begin
					for (int j = 0; j < c.h; j++)
						span_h(c.x, 8'(c.y + j), c.w);
				end else begin
					span_h(c.x, c.y, c.w);
					span_h(c.x, py2, c.w);
					span_v(c.x, c.y, c.h);
					span_v(px2, c.y, c.h);
				end
			end
			OP_FILL: for (int i = 0; i < PAGE_SZ; i++)
				pages[draw_sel][i] = c.pattern;
			OP_SWAP: swap_req = 1'b1;
			OP_XSTART: busy = 1'b1;
			OP_XDONE: begin
				busy = 1'b0;
				if (swap_req) begin
					draw_sel = ~draw_sel;
					swap_req = 1'b0;
				end
			end
			OP_DISP_RD: if (c.idx < PAGE_SZ)
				s.dbyte = pages[~draw_sel][c.idx];
			default: ;
		endcase
		s.swp = swap_req;
		s.xfer_ok = ~busy;
	endtask

	function automatic cmd_t rand_cmd(logic [3:0] op);
		cmd_t c;
		c = cmd_t'({$urandom, $urandom});
		c.op = op;
		// mostly in frame, sometimes anywhere
		if ($urandom_range(0, 3) != 0) begin
			c.x = 8'($urandom_range(0, COLS + 8));
			c.y = 8'($urandom_range(0, ROWS + 8));
		end
		if ($urandom_range(0, 3) != 0) begin
			c.len = 8'($urandom_range(0, 40));
			c.w = 8'($urandom_range(0, 24));
			c.h = 8'($urandom_range(0, 24));
		end
		if ($urandom_range(0, 3) != 0)
			c.idx = 10'($urandom_range(0, PAGE_SZ - 1));
		return c;
	endfunction

	function automatic cmd_t mk(logic [3:0] op, int px, int py, int n, int w, int h,
		bit on, bit fl);
		cmd_t c;
		c = rand_cmd(op);
		c.x = 8'(px);
		c.y = 8'(py);
		c.len = 8'(n);
		c.w = 8'(w);
		c.h = 8'(h);
		c.on = on;
		c.filled = fl;
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#20000000;
		$display("FAIL");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{operation, x_pos, y_pos, line_length, rect_width, rect_height, pixel_on,
				filled, fill_pattern, display_index} <= '0;
			in_gap <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				status_t s;
				apply_cmd(cmd_q.pop_front(), s);
				status_q.push_back(s);
			end
			if (in_valid && in_stall) begin
				// hold the stalled beat
			end else if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (cmd_q.size() > 0 && !hold_sender) begin
				cmd_t c;
				c = cmd_q[0];
				in_valid <= 1'b1;
				{operation, x_pos, y_pos, line_length, rect_width, rect_height, pixel_on,
					filled, fill_pattern, display_index} <= c;
				in_gap <= pick_gap();
			end else
				in_valid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_gap <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (status_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					status_t e;
					e = status_q.pop_front();
					if (pixel_value !== e.pix) begin
						$error("pixel_value exp %0d got %0d", e.pix, pixel_value);
						errors++;
					end
					if (display_byte !== e.dbyte) begin
						$error("display_byte exp %0h got %0h", e.dbyte, display_byte);
						errors++;
					end
					if (swap_waiting !== e.swp) begin
						$error("swap_waiting exp %0d got %0d", e.swp, swap_waiting);
						errors++;
					end
					if (can_transfer !== e.xfer_ok) begin
						$error("can_transfer exp %0d got %0d", e.xfer_ok, can_transfer);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_stall <= 1'b1;
				out_gap <= out_gap - 1;
			end else begin
				out_stall <= 1'b0;
				out_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
			end
		end
	end

	task automatic push(cmd_t c);
		cmd_q.push_back(c);
	endtask

	initial begin
		cmd_t c;
		int total;
		int r;
		errors = 0;
		hold_sender = 1'b0;
		for (int p = 0; p < 2; p++)
			for (int i = 0; i < PAGE_SZ; i++)
				pages[p][i] = 8'h00;
		draw_sel = 1'b0;
		swap_req = 1'b0;
		busy = 1'b0;

		// directed: corners, out of frame, clipping, wrap, every opcode
		push(mk(OP_PIX_WR, 0, 0, 0, 0, 0, 1, 0));
		push(mk(OP_PIX_WR, COLS - 1, ROWS - 1, 0, 0, 0, 1, 0));
		push(mk(OP_PIX_WR, 255, 255, 0, 0, 0, 1, 0));
		push(mk(OP_PIX_RD, COLS - 1, ROWS - 1, 0, 0, 0, 0, 0));
		push(mk(OP_PIX_RD, COLS, 0, 0, 0, 0, 0, 0));
		push(mk(OP_PIX_WR, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_PIX_RD, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_HLINE, 120, 5, 255, 0, 0, 0, 0));
		push(mk(OP_VLINE, 3, 60, 255, 0, 0, 0, 0));
		push(mk(OP_HLINE, 0, ROWS, 20, 0, 0, 0, 0));
		push(mk(OP_HLINE, 10, 10, 0, 0, 0, 0, 0));
		push(mk(OP_RECT, 10, 10, 0, 0, 5, 0, 0));
		push(mk(OP_RECT, 20, 20, 0, 6, 0, 0, 0));
		push(mk(OP_RECT, 30, 250, 0, 8, 20, 0, 1));
		push(mk(OP_RECT, 40, 30, 0, 0, 0, 0, 1));
		push(mk(OP_RECT, 60, 30, 0, 9, 0, 0, 1));
		push(mk(OP_RECT, 50, 40, 0, 255, 255, 0, 0));
		push(mk(OP_RECT, 4, 4, 0, 7, 9, 0, 1));
		push(mk(OP_DISP_RD, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_SWAP, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_XSTART, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_XSTART, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_XDONE, 0, 0, 0, 0, 0, 0, 0));
		push(mk(OP_XDONE, 0, 0, 0, 0, 0, 0, 0));
		c = mk(OP_DISP_RD, 0, 0, 0, 0, 0, 0, 0);
		c.idx = 10'h3ff;
		push(c);
		c = mk(OP_FILL, 0, 0, 0, 0, 0, 0, 0);
		c.pattern = 8'hff;
		push(c);
		push(mk(4'd15, 0, 0, 0, 0, 0, 0, 0));

		// let the directed part drain before random traffic
		wait (cmd_q.size() == 0);
		hold_sender = 1'b1;
		wait (status_q.size() == 0);
		hold_sender = 1'b0;

		total = 0;
		while (total < 400) begin
			r = $urandom_range(0, 99);
			if (r < 25) c = rand_cmd(OP_PIX_WR);
			else if (r < 40) c = rand_cmd(OP_PIX_RD);
			else if (r < 50) c = rand_cmd(OP_HLINE);
			else if (r < 60) c = rand_cmd(OP_VLINE);
			else if (r < 68) c = rand_cmd(OP_RECT);
			else if (r < 70) c = rand_cmd(OP_FILL);
			else if (r < 74) c = rand_cmd(OP_SWAP);
			else if (r < 79) c = rand_cmd(OP_XSTART);
			else if (r < 84) c = rand_cmd(OP_XDONE);
			else if (r < 97) c = rand_cmd(OP_DISP_RD);
			else c = rand_cmd(4'($urandom_range(10, 15)));
			push(c);
			total++;
			if (cmd_q.size() > 8)
				wait (cmd_q.size() <= 4);
		end

		wait (cmd_q.size() == 0 && !in_valid);
		wait (status_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && status_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
hdl/mfb_pkg.sv
hdl/mfb_ram.sv
hdl/mfb_front.sv
hdl/mfb_back.sv
hdl/mono_framebuffer_draw_engine.sv
dv/tb_mono_framebuffer_draw_engine.sv
